// ----- design/ldg_pkg.sv -----
package ldg_pkg;

    // quotient bits produced by the shared serial divider
    localparam int DIV_QW = 11;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [6:0] UTIL_FULL = 7'd100;

    localparam logic [CFG_IDX_W-1:0] REG_LOAD_TARGET   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_MAX      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT   = 8'd3;

    localparam logic [6:0] RST_LOAD_TARGET   = 7'd70;
    localparam logic [6:0] RST_LOAD_MAX      = 7'd90;
    localparam logic [7:0] RST_SMOOTH_WEIGHT = 8'd1;
    localparam logic [5:0] RST_LEVEL_COUNT   = 6'd1;

    typedef struct packed {
        logic [6:0] load_target;
        logic [6:0] load_max;
        logic [7:0] smooth_weight;
        logic [5:0] level_count;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_USTART,
        ST_UWAIT,
        ST_ANUM,
        ST_ASTART,
        ST_AWAIT,
        ST_LNUM,
        ST_LSTART,
        ST_LWAIT,
        ST_FIN
    } st_t;

    // x/3 for x < 128 as (x*43) >> 7
    function automatic logic [5:0] div3(input logic [6:0] x);
        logic [12:0] prod;
        prod = {6'b0, x} * 13'd43;
        return prod[12:7];
    endfunction

    // x*10 as two shifted adds
    function automatic logic [10:0] times10(input logic [6:0] x);
        return {1'b0, x, 3'b0} + {3'b0, x, 1'b0};
    endfunction

endpackage

// ----- design/ldg_cfg.sv -----
module ldg_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ldg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ldg_pkg::CFG_DATA_W-1:0]    cfg_data,
    output ldg_pkg::cfg_t                     cfg
);

    ldg_pkg::cfg_t cfg_reg;
    ldg_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                ldg_pkg::REG_LOAD_TARGET:   cfg_next.load_target   = cfg_data[6:0];
                ldg_pkg::REG_LOAD_MAX:      cfg_next.load_max      = cfg_data[6:0];
                ldg_pkg::REG_SMOOTH_WEIGHT: cfg_next.smooth_weight = cfg_data[7:0];
                ldg_pkg::REG_LEVEL_COUNT:   cfg_next.level_count   = cfg_data[5:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.load_target   <= ldg_pkg::RST_LOAD_TARGET;
            cfg_reg.load_max      <= ldg_pkg::RST_LOAD_MAX;
            cfg_reg.smooth_weight <= ldg_pkg::RST_SMOOTH_WEIGHT;
            cfg_reg.level_count   <= ldg_pkg::RST_LEVEL_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- design/ldg_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Caller guarantees rem_init < den and the quotient fits in QW bits.
module ldg_div
#(
    parameter int DW = 32,
    parameter int QW = 11
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] rem_init,
    input  logic [QW-1:0] num_lo,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [QW-1:0] quotient
);

    localparam int CNT_W = $clog2(QW);

    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    rem_next;
    logic [QW-1:0]    num_reg;
    logic [DW-1:0]    den_reg;
    logic [QW-1:0]    quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             qbit;

    assign trial = {rem_reg, num_reg[QW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign qbit  = !diff[DW];

    always_comb
    begin
        if (qbit)
            rem_next = diff[DW-1:0];
        else
            rem_next = trial[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QW - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            num_reg <= num_lo;
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[QW-2:0], 1'b0};
            quo_reg <= {quo_reg[QW-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !run_reg)
        else $error("divider restarted while running");

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(run_reg))
        else $error("divider done without a running pass");

endmodule

// ----- design/load_based_dvfs_governor_unit.sv -----
// Load-based performance level governor.
// Input stream (s_axis_*): one transaction per sampling tick with the busy and
// total cycle counts and the level now in effect. Output stream (m_axis_*): one
// transaction per input with the new level, a change flag, the smoothed load
// and the sample utilization. Config channel (cfg_*): register index and data,
// always ready; write only while no sample is in flight.
// Items are taken one at a time: a new input is accepted only once the
// previous one has reached the output register. One shared restoring divider
// yields one quotient bit per cycle and runs three 11-bit passes
// (utilization, smoothed load, proportional level step) one after another.
// The result sits in an output register; the next input is accepted while it
// waits. If the receiver stalls, the finished level of a following item is
// held until the output register frees up.
// Reset clears the smoothed load to 0 and loads the register defaults
// (target 70, max 90, weight 1, level count 1); no result is pending.
module load_based_dvfs_governor_unit
#(
    parameter int MAX_LEVELS    = 32,
    parameter int COUNTER_WIDTH = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] busy_count, [63:32] total_count, [68:64] current_level
    input  logic [71:0]                         s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [4:0] new_level, [5] level_changed, [12:6] smoothed_load,
    // [19:13] sample_utilization
    output logic [23:0]                         m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ldg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ldg_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int QW = ldg_pkg::DIV_QW;
    localparam int DW = (COUNTER_WIDTH > QW) ? COUNTER_WIDTH : QW;
    localparam int NW = COUNTER_WIDTH + 7;

    ldg_pkg::cfg_t cfg;
    ldg_pkg::st_t  state_reg;
    ldg_pkg::st_t  state_next;

    logic [COUNTER_WIDTH-1:0] busy_m;
    logic [COUNTER_WIDTH-1:0] total_m;
    logic                     in_accept;

    logic [NW-1:0]            nu_reg;
    logic [COUNTER_WIDTH-1:0] tot_reg;
    logic                     zero_tot_reg;
    logic                     over_reg;
    logic [4:0]               cur_reg;
    logic [6:0]               util_reg;
    logic [14:0]              anum_reg;
    logic [6:0]               avg_reg;
    logic [10:0]              mag_reg;
    logic                     neg_reg;
    logic [QW-1:0]            lq_reg;

    logic                     out_valid_reg;
    logic [23:0]              out_data_reg;

    logic                     div_start;
    logic [DW-1:0]            div_rem;
    logic [QW-1:0]            div_num;
    logic [DW-1:0]            div_den;
    logic                     div_done;
    logic [QW-1:0]            div_q;

    logic [6:0]               target_eff;
    logic [6:0]               count_eff;
    logic [5:0]               top;
    logic [8:0]               weight_p1;
    logic [7:0]               ldiff;
    logic [6:0]               ldiff_mag;
    logic [11:0]              cur12;
    logic [11:0]              step12;
    logic [11:0]              sum12;
    logic [5:0]               lvl;
    logic                     changed;
    logic                     out_load;

    ldg_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ldg_div #(.DW(DW), .QW(QW)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem),
        .num_lo   (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    assign busy_m    = s_axis_tdata[COUNTER_WIDTH-1:0];
    assign total_m   = s_axis_tdata[32 +: COUNTER_WIDTH];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // effective register values
    assign target_eff = (cfg.load_target == 7'd0) ? 7'd1 : cfg.load_target;
    always_comb
    begin
        if (cfg.level_count == 6'd0)
            count_eff = 7'd1;
        else if ({1'b0, cfg.level_count} > 7'(MAX_LEVELS))
            count_eff = 7'(MAX_LEVELS);
        else
            count_eff = {1'b0, cfg.level_count};
    end
    assign top       = 6'(count_eff - 7'd1);
    assign weight_p1 = {1'b0, cfg.smooth_weight} + 9'd1;

    assign ldiff     = {1'b0, avg_reg} - {1'b0, target_eff};
    assign ldiff_mag = ldiff[7] ? 7'(-ldiff) : ldiff[6:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ldg_pkg::ST_IDLE:   if (in_accept) state_next = ldg_pkg::ST_USTART;
            ldg_pkg::ST_USTART: state_next = ldg_pkg::ST_UWAIT;
            ldg_pkg::ST_UWAIT:  if (div_done) state_next = ldg_pkg::ST_ANUM;
            ldg_pkg::ST_ANUM:   state_next = ldg_pkg::ST_ASTART;
            ldg_pkg::ST_ASTART: state_next = ldg_pkg::ST_AWAIT;
            ldg_pkg::ST_AWAIT:  if (div_done) state_next = ldg_pkg::ST_LNUM;
            ldg_pkg::ST_LNUM:   state_next = ldg_pkg::ST_LSTART;
            ldg_pkg::ST_LSTART: state_next = ldg_pkg::ST_LWAIT;
            ldg_pkg::ST_LWAIT:  if (div_done) state_next = ldg_pkg::ST_FIN;
            ldg_pkg::ST_FIN:    if (out_load) state_next = ldg_pkg::ST_IDLE;
            default:            state_next = ldg_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        div_rem       = '0;
        div_num       = mag_reg;
        div_den       = DW'(target_eff);
        case (state_reg)
            ldg_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ldg_pkg::ST_USTART:
            begin
                div_start = 1'b1;
                div_rem   = DW'(nu_reg >> QW);
                div_num   = nu_reg[QW-1:0];
                div_den   = DW'(tot_reg);
            end
            ldg_pkg::ST_ASTART:
            begin
                div_start = 1'b1;
                div_rem   = DW'(anum_reg >> QW);
                div_num   = anum_reg[QW-1:0];
                div_den   = DW'(weight_p1);
            end
            ldg_pkg::ST_LSTART:
            begin
                div_start = 1'b1;
            end
            ldg_pkg::ST_FIN:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // level choice
    assign cur12 = 12'(cur_reg);
    always_comb
    begin
        step12 = 12'(lq_reg[QW-1:1]);
        if (avg_reg > cfg.load_max)
            sum12 = cur12 + 12'(ldg_pkg::div3(count_eff));
        else if (!neg_reg)
            sum12 = cur12 + step12;
        else if (step12 > cur12)
            sum12 = '0;
        else
            sum12 = cur12 - step12;
        lvl = (sum12 > 12'(top)) ? top : sum12[5:0];
    end
    assign changed = (lvl != {1'b0, cur_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ldg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            avg_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (state_reg == ldg_pkg::ST_AWAIT && div_done)
                avg_reg <= div_q[6:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            zero_tot_reg <= (total_m == '0);
            over_reg     <= (busy_m > total_m);
            cur_reg      <= s_axis_tdata[68:64];
            // special cases get a harmless 0/1 division
            if (total_m == '0 || busy_m > total_m)
            begin
                nu_reg  <= '0;
                tot_reg <= COUNTER_WIDTH'(1);
            end
            else
            begin
                nu_reg  <= NW'(busy_m) * NW'(ldg_pkg::UTIL_FULL);
                tot_reg <= total_m;
            end
        end
        if (state_reg == ldg_pkg::ST_UWAIT && div_done)
        begin
            if (zero_tot_reg)
                util_reg <= '0;
            else if (over_reg)
                util_reg <= ldg_pkg::UTIL_FULL;
            else
                util_reg <= div_q[6:0];
        end
        if (state_reg == ldg_pkg::ST_ANUM)
            anum_reg <= ({7'b0, cfg.smooth_weight} * {8'b0, avg_reg}) + {8'b0, util_reg};
        if (state_reg == ldg_pkg::ST_LNUM)
        begin
            mag_reg <= ldg_pkg::times10(ldiff_mag);
            neg_reg <= ldiff[7];
        end
        if (state_reg == ldg_pkg::ST_LWAIT && div_done)
            lq_reg <= div_q;
        if (out_load)
            out_data_reg <= {4'b0, util_reg, avg_reg, changed, lvl[4:0]};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int LEVEL_CAP       = 32;
    localparam int RANDOM_PHASES   = 14;
    localparam int ITEMS_PER_PHASE = 143;
    localparam int DRAIN_CYCLES    = 60;
    localparam int CYCLE_LIMIT     = 1000000;

    // packed so that busy_count lands in the low bits of tdata
    typedef struct packed {
        logic [4:0]  start_level;
        logic [31:0] total;
        logic [31:0] busy;
    } sample_t;

    typedef struct packed {
        logic [6:0] util;
        logic [6:0] smoothed;
        logic       changed;
        logic [4:0] new_level;
    } level_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    // [31:0] busy_count, [63:32] total_count, [68:64] current_level
    logic [71:0]                   s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    // [4:0] new_level, [5] level_changed, [12:6] smoothed_load,
    // [19:13] sample_utilization
    logic [23:0]                   m_axis_tdata;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [ldg_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ldg_pkg::CFG_DATA_W-1:0] cfg_data;

    sample_t       pending_samples[$];
    level_result_t expected_levels[$];

    ldg_pkg::cfg_t gov_cfg;
    logic [6:0]    gov_avg;
    level_result_t next_level;
    level_result_t seen_level;

    int  queued_items;
    int  accepted_items;
    int  cfg_writes;
    int  errors;
    int  cycle_count;
    int  in_idle_pct;
    int  out_idle_pct;
    int  in_hold;
    int  out_hold;
    int  level_span;
    bit  in_taken;

    load_based_dvfs_governor_unit #(
        .MAX_LEVELS    (LEVEL_CAP),
        .COUNTER_WIDTH (32)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // utilization, smoothed load and next level for one sample
    function automatic level_result_t govern(input sample_t s, input ldg_pkg::cfg_t c,
                                             input logic [6:0] avg_prev);
        logic [63:0]   busy64;
        logic [63:0]   total64;
        logic [63:0]   quot;
        logic [6:0]    util;
        int            avg;
        int            count;
        int            target;
        int            top;
        int            cur;
        int            lvl;
        level_result_t r;
        busy64  = {32'd0, s.busy};
        total64 = {32'd0, s.total};
        if (s.total == 32'd0)
            util = 7'd0;
        else if (s.busy > s.total)
            util = ldg_pkg::UTIL_FULL;
        else
        begin
            quot = (busy64 * 64'd100) / total64;
            util = quot[6:0];
        end
        avg = (int'(c.smooth_weight) * int'(avg_prev) + int'(util))
              / (int'(c.smooth_weight) + 1);
        count  = int'(c.level_count);
        target = int'(c.load_target);
        if (count < 1)
            count = 1;
        if (count > LEVEL_CAP)
            count = LEVEL_CAP;
        if (target < 1)
            target = 1;
        top = count - 1;
        cur = int'(s.start_level);
        r.smoothed = avg[6:0];
        if (int'(r.smoothed) > int'(c.load_max))
        begin
            lvl = cur + count / 3;
            if (lvl > top)
                lvl = top;
        end
        else
        begin
            // both divisions truncate toward zero
            lvl = cur + (((int'(r.smoothed) - target) * 10) / target) / 2;
            if (lvl < 0)
                lvl = 0;
            if (lvl > top)
                lvl = top;
        end
        r.new_level = lvl[4:0];
        r.changed   = (lvl != cur);
        r.util      = util;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
            flag_error($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    // model state, result checking and handshake bookkeeping
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            gov_cfg.load_target   = ldg_pkg::RST_LOAD_TARGET;
            gov_cfg.load_max      = ldg_pkg::RST_LOAD_MAX;
            gov_cfg.smooth_weight = ldg_pkg::RST_SMOOTH_WEIGHT;
            gov_cfg.level_count   = ldg_pkg::RST_LEVEL_COUNT;
            gov_avg  = 7'd0;
            in_taken = 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_level = m_axis_tdata[19:0];
                if (expected_levels.size() == 0)
                    flag_error("result transaction with nothing expected");
                else
                begin
                    next_level = expected_levels.pop_front();
                    check_field("new_level", int'(next_level.new_level),
                                int'(seen_level.new_level));
                    check_field("level_changed", int'(next_level.changed),
                                int'(seen_level.changed));
                    check_field("smoothed_load", int'(next_level.smoothed),
                                int'(seen_level.smoothed));
                    check_field("sample_utilization", int'(next_level.util),
                                int'(seen_level.util));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ldg_pkg::REG_LOAD_TARGET:   gov_cfg.load_target   = cfg_data[6:0];
                    ldg_pkg::REG_LOAD_MAX:      gov_cfg.load_max      = cfg_data[6:0];
                    ldg_pkg::REG_SMOOTH_WEIGHT: gov_cfg.smooth_weight = cfg_data[7:0];
                    ldg_pkg::REG_LEVEL_COUNT:   gov_cfg.level_count   = cfg_data[5:0];
                    default: ;
                endcase
                cfg_writes++;
            end
            in_taken = s_axis_tvalid && s_axis_tready;
            if (in_taken)
            begin
                next_level = govern(s_axis_tdata[68:0], gov_cfg, gov_avg);
                gov_avg = next_level.smoothed;
                expected_levels.push_back(next_level);
                accepted_items++;
            end
        end
    end

    // sample driver and result-side backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_taken)
            begin
                if (in_hold > 0)
                begin
                    in_hold--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    s_axis_tdata  <= {3'b000, pending_samples.pop_front()};
                    s_axis_tvalid <= 1'b1;
                    if ($urandom_range(1, 100) <= in_idle_pct)
                        in_hold = $urandom_range(1, 11);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            if (out_hold > 0)
            begin
                out_hold--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(1, 100) <= out_idle_pct)
                    out_hold = $urandom_range(1, 11);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("load_based_dvfs_governor_unit verification failed");
            $finish;
        end
    end

    task automatic queue_sample(input logic [31:0] busy, input logic [31:0] total,
                                input logic [4:0] cur);
        sample_t s;
        s.busy        = busy;
        s.total       = total;
        s.start_level = cur;
        pending_samples.push_back(s);
        queued_items++;
    endtask

    task automatic wait_idle();
        while (accepted_items != queued_items || expected_levels.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [ldg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        int seen;
        seen = cfg_writes;
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (cfg_writes == seen);
        cfg_valid <= 1'b0;
        if (idx == ldg_pkg::REG_LEVEL_COUNT)
        begin
            level_span = int'(val[5:0]);
            if (level_span < 1)
                level_span = 1;
            if (level_span > LEVEL_CAP)
                level_span = LEVEL_CAP;
        end
    endtask

    task automatic randomize_registers();
        logic [7:0] v;
        case ($urandom_range(0, 9))
            0:       v = 8'd0;
            1:       v = 8'd100;
            2:       v = 8'($urandom_range(101, 255));
            default: v = 8'($urandom_range(1, 100));
        endcase
        write_reg(ldg_pkg::REG_LOAD_TARGET, v);
        case ($urandom_range(0, 9))
            0:       v = 8'd0;
            1:       v = 8'd100;
            2:       v = 8'($urandom_range(101, 255));
            default: v = 8'($urandom_range(40, 100));
        endcase
        write_reg(ldg_pkg::REG_LOAD_MAX, v);
        case ($urandom_range(0, 9))
            0:       v = 8'd0;
            1:       v = 8'd255;
            2:       v = 8'($urandom_range(9, 254));
            default: v = 8'($urandom_range(0, 8));
        endcase
        write_reg(ldg_pkg::REG_SMOOTH_WEIGHT, v);
        case ($urandom_range(0, 9))
            0:       v = 8'd0;
            1:       v = 8'd32;
            2:       v = 8'($urandom_range(33, 255));
            default: v = 8'($urandom_range(1, 32));
        endcase
        write_reg(ldg_pkg::REG_LEVEL_COUNT, v);
    endtask

    function automatic sample_t random_sample(input int span);
        sample_t     s;
        logic [63:0] scaled;
        logic [31:0] mag;
        mag = ($urandom >> $urandom_range(0, 28)) | 32'd1;
        case ($urandom_range(0, 9))
            0:
            begin
                s.total = 32'd0;
                s.busy  = $urandom;
            end
            1:
            begin
                // busy overruns total; clamp if the add wraps
                s.total = mag;
                s.busy  = mag + 32'd1 + $urandom_range(0, 1000);
                if (s.busy <= s.total)
                    s.busy = 32'hFFFF_FFFF;
            end
            2:
            begin
                s.total = $urandom;
                s.busy  = $urandom;
            end
            default:
            begin
                s.total = mag;
                scaled  = ({32'd0, mag} * 64'($urandom_range(0, 100))) / 64'd100;
                s.busy  = scaled[31:0];
            end
        endcase
        if ($urandom_range(0, 9) < 7)
            s.start_level = 5'($urandom_range(0, span - 1));
        else
            s.start_level = 5'($urandom_range(0, 31));
        return s;
    endfunction

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        level_span    = int'(ldg_pkg::RST_LEVEL_COUNT);
        in_idle_pct   = 20;
        out_idle_pct  = 20;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // register defaults: one level only
        queue_sample(32'd0, 32'd0, 5'd0);
        queue_sample(32'd5, 32'd0, 5'd31);
        queue_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);
        queue_sample(32'd10, 32'd9, 5'd7);
        queue_sample(32'hFFFF_FFFF, 32'd1, 5'd3);
        wait_idle();

        // weight 0: load follows each sample directly
        write_reg(ldg_pkg::REG_LOAD_TARGET, 8'd50);
        write_reg(ldg_pkg::REG_LOAD_MAX, 8'd90);
        write_reg(ldg_pkg::REG_SMOOTH_WEIGHT, 8'd0);
        write_reg(ldg_pkg::REG_LEVEL_COUNT, 8'd32);
        queue_sample(32'd100, 32'd100, 5'd0);
        queue_sample(32'd100, 32'd100, 5'd25);
        queue_sample(32'd0, 32'd100, 5'd31);
        queue_sample(32'd0, 32'd100, 5'd2);
        queue_sample(32'd50, 32'd100, 5'd12);
        queue_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd16);
        queue_sample(32'hFFFF_FFFE, 32'hFFFF_FFFF, 5'd16);
        queue_sample(32'd90, 32'd100, 5'd16);
        queue_sample(32'd91, 32'd100, 5'd16);
        queue_sample(32'd57, 32'd100, 5'd5);
        // negative step of -1 halves to 0, not -1
        queue_sample(32'd43, 32'd100, 5'd5);
        queue_sample(32'h8000_0000, 32'd0, 5'd9);
        queue_sample(32'd1, 32'hFFFF_FFFF, 5'd30);
        wait_idle();

        // zero target and zero count fall back to 1; max above 100 disables jump
        write_reg(ldg_pkg::REG_LOAD_TARGET, 8'd0);
        write_reg(ldg_pkg::REG_LEVEL_COUNT, 8'd0);
        write_reg(ldg_pkg::REG_LOAD_MAX, 8'd127);
        write_reg(ldg_pkg::REG_SMOOTH_WEIGHT, 8'd255);
        queue_sample(32'd100, 32'd100, 5'd31);
        queue_sample(32'hFFFF_FFFF, 32'd3, 5'd0);
        queue_sample(32'd0, 32'd0, 5'd17);
        wait_idle();

        // count above the cap; unused index must be ignored
        write_reg(ldg_pkg::REG_LEVEL_COUNT, 8'd63);
        write_reg(ldg_pkg::REG_LOAD_TARGET, 8'd100);
        write_reg(ldg_pkg::REG_LOAD_MAX, 8'd100);
        write_reg(ldg_pkg::REG_SMOOTH_WEIGHT, 8'd1);
        write_reg(8'hA5, 8'hFF);
        queue_sample(32'd100, 32'd100, 5'd31);
        queue_sample(32'd100, 32'd100, 5'd20);
        queue_sample(32'd0, 32'd0, 5'd0);
        queue_sample(32'd100, 32'd100, 5'd4);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            randomize_registers();
            if (p == RANDOM_PHASES - 1)
            begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            else
            begin
                in_idle_pct  = 10 * $urandom_range(0, 3);
                out_idle_pct = 10 * $urandom_range(0, 3);
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                pending_samples.push_back(random_sample(level_span));
            queued_items += ITEMS_PER_PHASE;
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("load_based_dvfs_governor_unit verification clean");
        else
            $display("load_based_dvfs_governor_unit verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ldg_pkg.sv
design/ldg_cfg.sv
design/ldg_div.sv
design/load_based_dvfs_governor_unit.sv
bench/testbench.sv
